// ----- rtl/core/http_header_name_matcher_top_macros.svh -----
// Assertion macros shared by the header name matcher RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef HTTP_HEADER_NAME_MATCHER_TOP_MACROS_SVH
`define HTTP_HEADER_NAME_MATCHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HHNM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("header name matcher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HHNM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("header name matcher assertion failed");

`endif

// ----- rtl/core/hhnm_pkg.sv -----
// Package for the HTTP header field name matcher.
// Holds the name table, its lengths, the cell result type and the compare functions.
package hhnm_pkg;

    localparam int NAME_COUNT = 52;
    localparam int MAX_LEN    = 19;
    localparam int POS_W      = 5;
    localparam int ID_W       = 6;

    typedef logic [NAME_COUNT-1:0] t_entry_vec;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [ID_W-1:0]       t_id;

    localparam t_id        UNKNOWN_ID = t_id'(NAME_COUNT);
    localparam t_entry_vec ALIVE_ALL  = '1;

    typedef struct packed {
        t_entry_vec match;
        t_entry_vec ends;
    } t_cell_out;

    localparam logic [8*MAX_LEN-1:0] NAME_STR [NAME_COUNT] = '{
        "ACCEPT", "ACCEPT-CHARSET", "ACCEPT-ENCODING", "ACCEPT-LANGUAGE",
        "ACCEPT-RANGES", "AGE", "ALLOW", "AUTHORIZATION", "CACHE-CONTROL",
        "CONNECTION", "CONTENT-ENCODING", "CONTENT-LANGUAGE", "CONTENT-LENGTH",
        "CONTENT-LOCATION", "CONTENT-MD5", "CONTENT-RANGE", "CONTENT-TYPE",
        "COOKIE", "DATE", "ETAG", "EXPECT", "EXPIRES", "FROM", "HOST",
        "IF-MATCH", "IF-MODIFIED-SINCE", "IF-NONE-MATCH", "IF-RANGE",
        "IF-UNMODIFIED-SINCE", "KEEP-ALIVE", "LAST-MODIFIED", "LOCATION",
        "MAX-FORWARDS", "PRAGMA", "PROXY-AUTHENTICATE", "PROXY-AUTHORIZATION",
        "PROXY-CONNECTION", "RANGE", "REFERER", "RETRY-AFTER", "SERVER",
        "SET-COOKIE", "STATUS", "TE", "TRAILER", "TRANSFER-ENCODING", "UPGRADE",
        "USER-AGENT", "VARY", "VIA", "WARNING", "WWW-AUTHENTICATE"
    };

    localparam t_pos NAME_LEN [NAME_COUNT] = '{
        5'd6, 5'd14, 5'd15, 5'd15, 5'd13, 5'd3, 5'd5, 5'd13, 5'd13, 5'd10,
        5'd16, 5'd16, 5'd14, 5'd16, 5'd11, 5'd13, 5'd12, 5'd6, 5'd4, 5'd4,
        5'd6, 5'd7, 5'd4, 5'd4, 5'd8, 5'd17, 5'd13, 5'd8, 5'd19, 5'd10,
        5'd13, 5'd8, 5'd12, 5'd6, 5'd18, 5'd19, 5'd16, 5'd5, 5'd7, 5'd11,
        5'd6, 5'd10, 5'd6, 5'd2, 5'd7, 5'd17, 5'd7, 5'd10, 5'd4, 5'd3,
        5'd7, 5'd16
    };

    function automatic logic [7:0] fold_upper(input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        if (ch inside {[8'h61:8'h7A]}) begin
            res = ch - 8'h20;
        end
        return res;
    endfunction

    function automatic t_entry_vec col_match(input t_pos pos, input logic [7:0] ch);
        t_entry_vec m;
        m = '0;
        for (int k = 0; k < NAME_COUNT; k++) begin
            if (pos < NAME_LEN[k]) begin
                m[k] = (NAME_STR[k][8*(int'(NAME_LEN[k]) - 1 - int'(pos)) +: 8] == ch);
            end
        end
        return m;
    endfunction

    function automatic t_entry_vec col_end(input t_pos pos);
        t_entry_vec m;
        m = '0;
        for (int k = 0; k < NAME_COUNT; k++) begin
            m[k] = (NAME_LEN[k] == pos + t_pos'(1));
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/hhnm_cell.sv -----
// One byte-position cell of the header name matcher chain.
// Holds the position token and compares the current byte against its table column; uses hhnm_pkg.
module hhnm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hhnm_pkg::t_pos     i_cell_pos,
    input  logic               i_accept,
    input  logic               i_last,
    input  logic               i_token,
    input  logic [7:0]         i_byte_up,
    output logic               o_token,
    output hhnm_pkg::t_cell_out o_result
);
    import hhnm_pkg::*;

    logic r_token;
    logic n_token;

    always_comb begin
        n_token = r_token;
        if (i_accept) begin
            n_token = i_last ? (i_cell_pos == '0) : i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= (i_cell_pos == '0);
        end else begin
            r_token <= n_token;
        end
    end

    assign o_token        = r_token;
    assign o_result.match = r_token ? col_match(i_cell_pos, i_byte_up) : '0;
    assign o_result.ends  = r_token ? col_end(i_cell_pos) : '0;

endmodule

// ----- rtl/core/http_header_name_matcher_top.sv -----
// Top level of the HTTP header field name matcher.
// Instantiates the hhnm_cell chain and holds the alive vector and output register; uses hhnm_pkg.
//
// The block takes one name byte per cycle, back to back, with no gaps needed between
// names. A row of 19 cells, one per byte position of the longest table name, passes a
// position token along on every transfer; the cell that holds it compares the
// case-folded byte against its column of the table. The result of a name appears in
// the output register in the cycle after the transfer of its last byte. Bytes that are not
// the last produce no result. The input stalls only while a result waits and the
// output side stalls.
`include "http_header_name_matcher_top_macros.svh"

module http_header_name_matcher_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_name_byte,
    input  logic            i_last_byte,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output hhnm_pkg::t_id   o_header_id,
    output logic            o_found
);
    import hhnm_pkg::*;

    logic                  w_accept;
    logic                  w_out_fire;
    logic [7:0]            w_byte_up;
    logic [MAX_LEN-1:0]    w_tokens;
    logic [MAX_LEN-1:0]    w_token_in;
    t_cell_out             w_cell_res [MAX_LEN];
    t_entry_vec            w_match_any;
    t_entry_vec            w_end_any;
    t_entry_vec            w_next_alive;
    t_entry_vec            w_hit;
    t_id                   w_id;

    t_entry_vec            r_alive;
    t_entry_vec            n_alive;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_id                   r_header_id;
    t_id                   n_header_id;
    logic                  r_found;
    logic                  n_found;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_out_fire = r_out_valid & ~i_out_stall;
    assign w_byte_up  = fold_upper(i_name_byte);
    assign w_token_in = {w_tokens[MAX_LEN-2:0], 1'b0};

    for (genvar p = 0; p < MAX_LEN; p++) begin : g_cell
        hhnm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_pos (t_pos'(p)),
            .i_accept   (w_accept),
            .i_last     (i_last_byte),
            .i_token    (w_token_in[p]),
            .i_byte_up  (w_byte_up),
            .o_token    (w_tokens[p]),
            .o_result   (w_cell_res[p])
        );
    end

    always_comb begin
        w_match_any = '0;
        w_end_any   = '0;
        for (int p = 0; p < MAX_LEN; p++) begin
            w_match_any = w_match_any | w_cell_res[p].match;
            w_end_any   = w_end_any | w_cell_res[p].ends;
        end
        w_next_alive = r_alive & w_match_any;
        w_hit        = w_next_alive & w_end_any;
    end

    always_comb begin
        w_id = '0;
        for (int k = 0; k < NAME_COUNT; k++) begin
            if (w_hit[k]) begin
                w_id = w_id | t_id'(k);
            end
        end
        if (w_hit == '0) begin
            w_id = UNKNOWN_ID;
        end
    end

    always_comb begin
        n_alive     = r_alive;
        n_out_valid = r_out_valid;
        n_header_id = r_header_id;
        n_found     = r_found;
        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_alive = i_last_byte ? ALIVE_ALL : w_next_alive;
            if (i_last_byte) begin
                n_out_valid = 1'b1;
                n_header_id = w_id;
                n_found     = |w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= ALIVE_ALL;
            r_out_valid <= 1'b0;
        end else begin
            r_alive     <= n_alive;
            r_out_valid <= n_out_valid;
        end
        r_header_id <= n_header_id;
        r_found     <= n_found;
    end

    assign o_out_valid = r_out_valid;
    assign o_header_id = r_header_id;
    assign o_found     = r_found;

    `HHNM_ASSERT_NOW(a_hit_onehot, 1'b1, $onehot0(w_hit))
    `HHNM_ASSERT_NOW(a_token_onehot, 1'b1, $onehot0(w_tokens))
    `HHNM_ASSERT_NEXT(a_restart_after_last, w_accept && i_last_byte, r_alive == ALIVE_ALL && w_tokens[0])
    `HHNM_ASSERT_NOW(a_found_matches_id, r_out_valid, r_found == (r_header_id != UNKNOWN_ID))

endmodule
